FILE: design/eipv4rx_pkg.sv
// Shared types, constants and ones'-complement helpers for the IPv4 receive classifier.
// No dependencies; imported by eipv4rx_parser and eth_ipv4_rx_classifier_unit.
package eipv4rx_pkg;

    // Default frame length limit, in bytes
    localparam int C_MAX_FRAME_BYTES = 2048;

    // Ethertypes and IP protocol numbers
    localparam logic [15:0] C_ETH_IPV4   = 16'h0800;
    localparam logic [15:0] C_ETH_ARP    = 16'h0806;
    localparam logic [7:0]  C_PROTO_ICMP = 8'h01;
    localparam logic [7:0]  C_PROTO_UDP  = 8'h11;
    localparam logic [7:0]  C_PROTO_TCP  = 8'h06;
    localparam logic [7:0]  C_ICMP_ECHO_REQ = 8'h08;
    localparam logic [15:0] C_ONES       = 16'hFFFF;

    // Number of leading transport bytes kept until end of frame
    localparam int C_HEAD_BYTES = 10;

    // Frame byte positions
    localparam int C_POS_ETYPE_HI     = 12;
    localparam int C_POS_ETYPE_LO     = 13;
    localparam int C_POS_IHL          = 14;
    localparam int C_POS_TLEN_HI      = 16;
    localparam int C_POS_TLEN_LO      = 17;
    localparam int C_POS_PROTO        = 23;
    localparam int C_POS_PSEUDO_FIRST = 26;
    localparam int C_POS_PSEUDO_LAST  = 33;
    localparam int C_POS_DIP_FIRST    = 30;
    localparam int C_POS_DIP_LAST     = 33;
    localparam int C_POS_IP_DONE      = 34;
    localparam int C_POS_TPA_FIRST    = 38;
    localparam int C_POS_TPA_LAST     = 41;
    localparam int C_POS_ARP_DONE     = 42;

    // Offsets inside the transport header
    localparam int C_TOFF_ICMP_TYPE  = 0;
    localparam int C_TOFF_UDP_LEN_HI = 4;
    localparam int C_TOFF_UDP_LEN_LO = 5;
    localparam int C_UDP_MIN_SEEN    = 6;

    // Classification flags of one frame
    typedef struct packed {
        logic ip_valid;
        logic ip_unicast;
        logic ping_request;
        logic arp_for_us;
        logic udp_valid;
        logic tcp_valid;
    } t_flags;

    // Ones'-complement add with end-around carry; zero stays zero only for zero inputs
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[16]) begin
            oc_add = s[15:0] + 16'd1;
        end else begin
            oc_add = s[15:0];
        end
    endfunction

    // True when four folded sums combine to all ones (a nonzero multiple of 0xFFFF)
    function automatic logic sum_ok(input logic [15:0] a, input logic [15:0] b,
                                    input logic [15:0] c, input logic [15:0] d);
        logic [17:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        sum_ok = (s == 18'd65535) || (s == 18'd131070) ||
                 (s == 18'd196605) || (s == 18'd262140);
    endfunction

endpackage

FILE: design/eth_ipv4_rx_classifier_unit.sv
// Top level of the IPv4 receive classifier: input register, parser, result register.
// Depends on eipv4rx_pkg and eipv4rx_parser.
//
// Takes one received frame byte per cycle unless a last byte is held back, destination
// MAC first, and on the byte marked as last delivers one result with six flags: IPv4
// header checksum good, destination IP equal to the local address, ICMP echo request,
// ARP target equal to the local address, and UDP and TCP checksums (pseudo-header
// included) good. The last byte passes through the input register and then the
// result register. While a result waits in the output register, ordinary bytes keep
// flowing and only the next last byte holds in the input register. Bytes past
// MAX_FRAME_BYTES are dropped but a last-byte mark on them still yields a result.
// Write local_ip only while no frame is in flight.
module eth_ipv4_rx_classifier_unit #(
    parameter int MAX_FRAME_BYTES = eipv4rx_pkg::C_MAX_FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // frame byte channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_end_of_frame,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ip_valid,
    output logic        o_ip_unicast,
    output logic        o_ping_request,
    output logic        o_arp_for_us,
    output logic        o_udp_valid,
    output logic        o_tcp_valid,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import eipv4rx_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;
    logic        r_out_valid;
    t_flags      r_out_flags;
    logic [31:0] r_local_ip;
    logic        w_step;
    t_flags      w_flags;

    // Advance a byte unless it closes a frame while the result register is full and not being taken
    assign w_step  = r_in_valid && (!r_in_eof || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_frame_byte;
            r_in_eof  <= i_end_of_frame;
        end
    end

    // Local address register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= 32'h0000_0000;
        end else if (i_cfg_valid) begin
            r_local_ip <= i_cfg_data;
        end
    end

    eipv4rx_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (r_in_byte),
        .i_eof      (r_in_eof),
        .i_local_ip (r_local_ip),
        .o_flags    (w_flags)
    );

    // Result register: load on a closing byte, drop once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_eof) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_eof) begin
            r_out_flags <= w_flags;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_ip_valid     = r_out_flags.ip_valid;
    assign o_ip_unicast   = r_out_flags.ip_unicast;
    assign o_ping_request = r_out_flags.ping_request;
    assign o_arp_for_us   = r_out_flags.arp_for_us;
    assign o_udp_valid    = r_out_flags.udp_valid;
    assign o_tcp_valid    = r_out_flags.tcp_valid;

endmodule

FILE: design/eipv4rx_parser.sv
// Per-frame byte parser: position counter, captured header fields, running checksums.
// Produces the classification flags for the byte being taken. Depends on eipv4rx_pkg.
module eipv4rx_parser #(
    parameter int MAX_FRAME_BYTES = eipv4rx_pkg::C_MAX_FRAME_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_eof,
    input  logic [31:0]           i_local_ip,
    output eipv4rx_pkg::t_flags   o_flags
);
    import eipv4rx_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    typedef struct packed {
        logic [15:0] ether_type;
        logic [3:0]  hlw;
        logic [15:0] total_len;
        logic [7:0]  proto;
        logic [7:0]  icmp_kind;
        logic [15:0] udp_len;
        logic        dest_match;
        logic        arp_match;
        logic [15:0] hdr_sum;
        logic [15:0] tp_sum;
        logic [15:0] tp_seen;
        logic [15:0] head_run;
    } t_state;

    localparam t_state C_CLEAR = '{
        ether_type: 16'h0000, hlw: 4'h0, total_len: 16'h0000, proto: 8'h00,
        icmp_kind: 8'h00, udp_len: 16'h0000, dest_match: 1'b1, arp_match: 1'b1,
        hdr_sum: 16'h0000, tp_sum: 16'h0000, tp_seen: 16'h0000, head_run: 16'h0000
    };

    logic [POS_W-1:0] r_pos, n_pos;
    t_state           r_st, n_st;
    logic [15:0]      r_head_pre [C_HEAD_BYTES];
    logic [15:0]      n_head_pre [C_HEAD_BYTES];

    logic             w_take;
    logic [15:0]      w_lane;
    logic [3:0]       w_hlw;
    logic [6:0]       w_tstart;
    logic             w_in_tp;
    logic [POS_W-1:0] w_toff;
    logic [15:0]      w_tcp_cur;
    logic [15:0]      w_cover;
    logic [1:0]       w_oct_sel;
    logic [7:0]       w_oct;
    logic [15:0]      w_head_sum;

    logic [15:0]      w_udp_lim, w_tcp_lim;
    logic [3:0]       w_udp_n, w_tcp_n;
    logic [15:0]      w_udp_head, w_tcp_head;
    logic             w_pos_ip, w_pos_arp;
    logic             w_udp_ok, w_tcp_ok;

    // Per-byte decode of the current frame position
    always_comb begin
        w_take     = (r_pos != POS_MAX);
        w_lane     = r_pos[0] ? {8'h00, i_byte} : {i_byte, 8'h00};
        w_hlw      = (r_pos == POS_W'(C_POS_IHL)) ? i_byte[3:0] : r_st.hlw;
        w_tstart   = 7'(C_POS_IHL) + {1'b0, w_hlw, 2'b00};
        w_in_tp    = (r_pos >= POS_W'(w_tstart));
        w_toff     = r_pos - POS_W'(w_tstart);
        w_tcp_cur  = r_st.total_len - {10'd0, r_st.hlw, 2'b00};
        w_head_sum = oc_add(r_st.head_run, w_lane);
        w_oct_sel  = r_pos[1:0] ^ 2'b10;
        case (w_oct_sel)
            2'd0:    w_oct = i_local_ip[31:24];
            2'd1:    w_oct = i_local_ip[23:16];
            2'd2:    w_oct = i_local_ip[15:8];
            default: w_oct = i_local_ip[7:0];
        endcase
        case (r_st.proto)
            C_PROTO_UDP: w_cover = r_st.udp_len;
            C_PROTO_TCP: w_cover = w_tcp_cur;
            default:     w_cover = 16'h0000;
        endcase
    end

    // Fold the byte into the captured fields and sums
    always_comb begin
        n_st       = r_st;
        n_pos      = r_pos;
        n_head_pre = r_head_pre;
        if (w_take) begin
            if (r_pos == POS_W'(C_POS_ETYPE_HI)) n_st.ether_type = {i_byte, 8'h00};
            if (r_pos == POS_W'(C_POS_ETYPE_LO)) n_st.ether_type = r_st.ether_type | {8'h00, i_byte};
            if (r_pos == POS_W'(C_POS_IHL))      n_st.hlw = i_byte[3:0];
            if (r_pos == POS_W'(C_POS_TLEN_HI))  n_st.total_len = {i_byte, 8'h00};
            if (r_pos == POS_W'(C_POS_TLEN_LO))  n_st.total_len = r_st.total_len | {8'h00, i_byte};
            if (r_pos == POS_W'(C_POS_PROTO))    n_st.proto = i_byte;

            // IP header sum
            if (r_pos >= POS_W'(C_POS_IHL) && r_pos < POS_W'(w_tstart)) begin
                n_st.hdr_sum = oc_add(r_st.hdr_sum, w_lane);
            end

            // Pseudo-header addresses
            if (r_pos >= POS_W'(C_POS_PSEUDO_FIRST) && r_pos <= POS_W'(C_POS_PSEUDO_LAST)) begin
                n_st.tp_sum = oc_add(r_st.tp_sum, w_lane);
            end

            // Address compares against the local address
            if (r_pos >= POS_W'(C_POS_DIP_FIRST) && r_pos <= POS_W'(C_POS_DIP_LAST) &&
                i_byte != w_oct) begin
                n_st.dest_match = 1'b0;
            end
            if (r_pos >= POS_W'(C_POS_TPA_FIRST) && r_pos <= POS_W'(C_POS_TPA_LAST) &&
                i_byte != w_oct) begin
                n_st.arp_match = 1'b0;
            end

            // Transport bytes
            if (w_in_tp) begin
                if (w_toff == POS_W'(C_TOFF_ICMP_TYPE))  n_st.icmp_kind = i_byte;
                if (w_toff == POS_W'(C_TOFF_UDP_LEN_HI)) n_st.udp_len = {i_byte, 8'h00};
                if (w_toff == POS_W'(C_TOFF_UDP_LEN_LO)) n_st.udp_len = r_st.udp_len | {8'h00, i_byte};
                if (w_toff < POS_W'(C_HEAD_BYTES)) begin
                    n_st.head_run = w_head_sum;
                    n_head_pre[w_toff[3:0]] = w_head_sum;
                end else if (16'(w_toff) < w_cover) begin
                    n_st.tp_sum = oc_add(n_st.tp_sum, w_lane);
                end
                if (r_st.tp_seen != C_ONES) begin
                    n_st.tp_seen = r_st.tp_seen + 16'd1;
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Classification from the state after this byte
    always_comb begin
        w_udp_lim = n_st.udp_len;
        w_tcp_lim = n_st.total_len - {10'd0, n_st.hlw, 2'b00};
        w_udp_n   = (w_udp_lim >= 16'(C_HEAD_BYTES)) ? 4'(C_HEAD_BYTES) : w_udp_lim[3:0];
        w_tcp_n   = (w_tcp_lim >= 16'(C_HEAD_BYTES)) ? 4'(C_HEAD_BYTES) : w_tcp_lim[3:0];
        w_udp_head = (w_udp_n == 4'd0) ? 16'h0000 : n_head_pre[w_udp_n - 4'd1];
        w_tcp_head = (w_tcp_n == 4'd0) ? 16'h0000 : n_head_pre[w_tcp_n - 4'd1];
        w_pos_ip  = (n_pos >= POS_W'(C_POS_IP_DONE));
        w_pos_arp = (n_pos >= POS_W'(C_POS_ARP_DONE));

        w_udp_ok = w_pos_ip && (n_st.tp_seen >= w_udp_lim) &&
                   sum_ok(n_st.tp_sum, w_udp_head, {8'h00, n_st.proto}, w_udp_lim);
        w_tcp_ok = w_pos_ip && (n_st.tp_seen >= w_tcp_lim) &&
                   sum_ok(n_st.tp_sum, w_tcp_head, {8'h00, n_st.proto}, w_tcp_lim);

        o_flags.ip_valid     = (n_st.ether_type == C_ETH_IPV4) && (n_st.hdr_sum == C_ONES);
        o_flags.ip_unicast   = n_st.dest_match && w_pos_ip;
        o_flags.ping_request = (n_st.proto == C_PROTO_ICMP) && (n_st.icmp_kind == C_ICMP_ECHO_REQ);
        o_flags.arp_for_us   = (n_st.ether_type == C_ETH_ARP) && n_st.arp_match && w_pos_arp;
        o_flags.udp_valid    = (n_st.proto == C_PROTO_UDP) &&
                               (n_st.tp_seen >= 16'(C_UDP_MIN_SEEN)) && w_udp_ok;
        o_flags.tcp_valid    = (n_st.proto == C_PROTO_TCP) && w_tcp_ok;
    end

    // Advance the frame state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_st  <= C_CLEAR;
        end else if (i_step) begin
            if (i_eof) begin
                r_pos <= '0;
                r_st  <= C_CLEAR;
            end else begin
                r_pos <= n_pos;
                r_st  <= n_st;
            end
        end
    end

    // Hold the running sums over the leading transport bytes
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_head_pre <= n_head_pre;
        end
    end

endmodule
